### hdl/contiguous_segment_allocator_macros.svh
// Assertion macros for the contiguous segment allocator.
`ifndef CONTIGUOUS_SEGMENT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_SEGMENT_ALLOCATOR_MACROS_SVH
// Assert that an antecedent implies a consequent on the same edge.
`define CSA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Assert that an antecedent implies a consequent on the next edge.
`define CSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### hdl/csa_pkg.sv
// Package with types and constants of the contiguous segment allocator.
package csa_pkg;
   localparam int MaxSegments = 32;
   localparam int MaxFrames   = 1024;
   localparam int FrameWidth  = 11;
   localparam int StartWidth  = 10;
   localparam int OwnerWidth  = 8;
   localparam int StatusWidth = 3;

   localparam logic [StatusWidth-1:0] StatPlaced    = 3'd0;
   localparam logic [StatusWidth-1:0] StatCompacted = 3'd1;
   localparam logic [StatusWidth-1:0] StatSkipped   = 3'd2;
   localparam logic [StatusWidth-1:0] StatReleased  = 3'd3;
   localparam logic [StatusWidth-1:0] StatNotFound  = 3'd4;

   localparam logic CsrFitPolicy = 1'b0;
   localparam logic CsrMemFrames = 1'b1;
   localparam logic FuncAlloc    = 1'b0;
   localparam logic FuncRelease  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_SCAN, ST_DECIDE, ST_SHIFT, ST_COMPACT, ST_TAIL,
      ST_PLACE, ST_MERGE, ST_DONE
   } state_type;
endpackage

### hdl/csa_if.sv
// Valid/ready channel interfaces of the contiguous segment allocator.
interface csa_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [csa_pkg::OwnerWidth-1:0] owner_id;
   logic [csa_pkg::FrameWidth-1:0] req_frames;
   modport source (output valid, func, owner_id, req_frames, input ready);
   modport sink   (input valid, func, owner_id, req_frames, output ready);
endinterface

interface csa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [csa_pkg::StatusWidth-1:0] status;
   logic [csa_pkg::StartWidth-1:0]  start_frame;
   logic [csa_pkg::FrameWidth-1:0]  frames_moved;
   logic [csa_pkg::FrameWidth-1:0]  free_left;
   modport source (output valid, status, start_frame, frames_moved, free_left, input ready);
   modport sink   (input valid, status, start_frame, frames_moved, free_left, output ready);
endinterface

interface csa_csr_if;
   logic                           valid;
   logic                           ready;
   logic                           index;
   logic [csa_pkg::FrameWidth-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hdl/contiguous_segment_allocator.sv
// Top level of the contiguous segment allocator: sequencer around a segment table.
// An item takes one pass over the table to scan it, and a split, a compaction or a merge
// adds a second pass, one entry a cycle through the single table read port. The next
// item is accepted once the result has been taken. Reset and a memory_frames write start
// a clearing pass that rebuilds one free segment; no item is accepted during it.
module contiguous_segment_allocator #(
   parameter int MAX_SEGMENTS = csa_pkg::MaxSegments,
   parameter int MAX_FRAMES   = csa_pkg::MaxFrames
) (
   input logic        clock,
   input logic        reset,
   csa_req_if.sink    req,
   csa_rsp_if.source  rsp,
   csa_csr_if.sink    csr
);
   import csa_pkg::*;
   `include "contiguous_segment_allocator_macros.svh"

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int FW = FrameWidth;

   // Control state.
   state_type state_ff, state_in;
   logic          fit_ff, fit_in;
   logic [FW-1:0] mem_frames_ff, mem_frames_in;
   logic [CW-1:0] count_ff, count_in;
   logic [FW-1:0] free_ff, free_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Per-item work registers.
   logic          func_ff, func_in;
   logic [OwnerWidth-1:0] owner_ff, owner_in;
   logic [FW-1:0] reqf_ff, reqf_in;
   logic [CW-1:0] ptr_ff, ptr_in;       // address being issued
   logic          pend_ff, pend_in;     // read data valid next cycle
   logic [CW-1:0] pidx_ff, pidx_in;     // index of returning read data
   logic [FW-1:0] addr_ff, addr_in;     // running start address
   logic          have_ff, have_in;
   logic [CW-1:0] best_ff, best_in;
   logic [FW-1:0] bdiff_ff, bdiff_in;
   logic [FW-1:0] bstart_ff, bstart_in;
   logic [FW-1:0] bsize_ff, bsize_in;
   logic [CW-1:0] used_n_ff, used_n_in;
   logic          hole_ff, hole_in;
   logic [FW-1:0] moved_ff, moved_in;
   logic [CW-1:0] wptr_ff, wptr_in;
   logic [FW-1:0] prevsz_ff, prevsz_in; // size of entry before the found one
   logic          prevfree_ff, prevfree_in;
   logic          merge_l_ff, merge_l_in;
   logic          merge_r_ff, merge_r_in;
   logic [FW-1:0] nextsz_ff, nextsz_in;
   logic          shift_up_ff, shift_up_in; // merge phase: set once the merged entry is written
   logic [1:0]    rem_ff, rem_in;       // entries removed by merge
   logic [CW-1:0] tgt_ff, tgt_in;       // target index for place / merge
   logic [StatusWidth-1:0] st_ff, st_in;
   logic [StartWidth-1:0]  start_ff, start_in;
   logic [FW-1:0]          rmoved_ff, rmoved_in;

   // Table port.
   logic          wr_en;
   logic [IW-1:0] wr_idx, rd_idx;
   logic [FW-1:0] wr_size, rd_size;
   logic [OwnerWidth-1:0] wr_owner, rd_owner;
   logic          wr_used, rd_used;

   csa_table #(.MAX_SEGMENTS(MAX_SEGMENTS), .FW(FW)) u_table (
      .clock, .wr_en, .wr_idx, .wr_size, .wr_owner, .wr_used,
      .rd_idx, .rd_size, .rd_owner, .rd_used
   );

   logic [FW-1:0] csr_clamp;
   always_comb begin
      csr_clamp = csr.data;
      if (csr.data == '0) csr_clamp = FW'(1);
      else if (32'(csr.data) > MAX_FRAMES) csr_clamp = FW'(MAX_FRAMES);
   end

   // A register write wins over an item offered in the same cycle, and registers are
   // only written while no item is in flight and no result is waiting.
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff && !csr.valid;
   assign csr.ready = ((state_ff == ST_IDLE) || (state_ff == ST_INIT)) && !rsp_valid_ff;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = st_ff;
   assign rsp.start_frame  = start_ff;
   assign rsp.frames_moved = rmoved_ff;
   assign rsp.free_left    = free_ff;

   logic [FW-1:0] diff;
   logic          rd_ok;
   always_comb begin
      diff  = rd_size - reqf_ff;
      rd_ok = pend_ff && (pidx_ff < count_ff);
   end

   always_comb begin
      state_in = state_ff; fit_in = fit_ff; mem_frames_in = mem_frames_ff;
      count_in = count_ff; free_in = free_ff; rsp_valid_in = rsp_valid_ff;
      func_in = func_ff; owner_in = owner_ff; reqf_in = reqf_ff;
      ptr_in = ptr_ff; pend_in = 1'b0; pidx_in = ptr_ff; addr_in = addr_ff;
      have_in = have_ff; best_in = best_ff; bdiff_in = bdiff_ff;
      bstart_in = bstart_ff; bsize_in = bsize_ff; used_n_in = used_n_ff;
      hole_in = hole_ff; moved_in = moved_ff; wptr_in = wptr_ff;
      prevsz_in = prevsz_ff; prevfree_in = prevfree_ff;
      merge_l_in = merge_l_ff; merge_r_in = merge_r_ff; nextsz_in = nextsz_ff;
      shift_up_in = shift_up_ff; rem_in = rem_ff; tgt_in = tgt_ff;
      st_in = st_ff; start_in = start_ff; rmoved_in = rmoved_ff;
      wr_en = 1'b0; wr_idx = '0; wr_size = '0; wr_owner = '0; wr_used = 1'b0;
      rd_idx = ptr_ff[IW-1:0];

      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               func_in = req.func; owner_in = req.owner_id; reqf_in = req.req_frames;
               ptr_in = '0; addr_in = '0; have_in = 1'b0; used_n_in = '0;
               hole_in = 1'b0; moved_in = '0; wptr_in = '0; prevfree_in = 1'b0;
               prevsz_in = '0; st_in = StatSkipped; start_in = '0; rmoved_in = '0;
               if (req.func == FuncAlloc &&
                   (req.req_frames == '0 || req.req_frames > free_ff))
                  state_in = ST_DONE;
               else state_in = ST_SCAN;
            end
         end
         ST_INIT: begin
            // Clearing pass: entry 0 gets the memory size, others zero.
            wr_en = 1'b1; wr_idx = ptr_ff[IW-1:0];
            wr_size = (ptr_ff == '0) ? mem_frames_ff : '0;
            ptr_in = ptr_ff + CW'(1);
            if (32'(ptr_ff) == MAX_SEGMENTS - 1) begin
               state_in = ST_IDLE; count_in = CW'(1); free_in = mem_frames_ff;
            end
         end
         ST_SCAN: begin
            // One read issued per cycle; the data returns in the next cycle.
            if (ptr_ff < count_ff) begin
               pend_in = 1'b1; pidx_in = ptr_ff; ptr_in = ptr_ff + CW'(1);
            end
            if (rd_ok) begin
               addr_in = addr_ff + rd_size;
               if (func_ff == FuncRelease) begin
                  if (!have_ff) begin
                     if (rd_used && rd_owner == owner_ff) begin
                        have_in = 1'b1; best_in = pidx_ff; bstart_in = addr_ff;
                        bsize_in = rd_size;
                     end else begin
                        prevfree_in = !rd_used; prevsz_in = rd_size;
                     end
                  end else if (pidx_ff == best_ff + CW'(1)) begin
                     nextsz_in = rd_size; merge_r_in = !rd_used;
                  end
               end else begin
                  if (rd_used) used_n_in = used_n_ff + CW'(1);
                  if (!rd_used && rd_size >= reqf_ff &&
                      (!have_ff || (fit_ff && diff < bdiff_ff))) begin
                     if (!(have_ff && !fit_ff)) begin
                        have_in = 1'b1; best_in = pidx_ff; bdiff_in = diff;
                        bstart_in = addr_ff; bsize_in = rd_size;
                     end
                  end
               end
            end
            if (ptr_ff >= count_ff && !rd_ok && !pend_ff) begin
               state_in = ST_DECIDE;
               if (func_ff == FuncRelease && have_ff && best_ff + CW'(1) >= count_ff)
                  merge_r_in = 1'b0;
            end
         end
         ST_DECIDE: begin
            if (func_ff == FuncRelease) begin
               if (!have_ff) begin
                  st_in = StatNotFound; state_in = ST_DONE;
               end else begin
                  st_in = StatReleased; start_in = bstart_ff[StartWidth-1:0];
                  free_in = free_ff + bsize_ff;
                  merge_l_in = prevfree_ff && best_ff != '0;
                  // Merged segment lands at tgt; entries after it shift down.
                  tgt_in = (prevfree_ff && best_ff != '0) ? best_ff - CW'(1) : best_ff;
                  rem_in = 2'((prevfree_ff && best_ff != '0)) + 2'(merge_r_ff);
                  state_in = ST_MERGE;
               end
            end else if (have_ff) begin
               if (bsize_ff == reqf_ff) begin
                  wr_en = 1'b1; wr_idx = best_ff[IW-1:0]; wr_size = reqf_ff;
                  wr_owner = owner_ff; wr_used = 1'b1;
                  st_in = StatPlaced; start_in = bstart_ff[StartWidth-1:0];
                  free_in = free_ff - reqf_ff; state_in = ST_DONE;
               end else if (32'(count_ff) < MAX_SEGMENTS) begin
                  st_in = StatPlaced; start_in = bstart_ff[StartWidth-1:0];
                  tgt_in = best_ff; ptr_in = count_ff; shift_up_in = 1'b1;
                  state_in = ST_SHIFT;
               end else state_in = ST_DONE;
            end else begin
               if (32'(used_n_ff) + 1 + ((free_ff > reqf_ff) ? 1 : 0) <= MAX_SEGMENTS) begin
                  ptr_in = '0; wptr_in = '0; hole_in = 1'b0; moved_in = '0;
                  state_in = ST_COMPACT;
               end else state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            // Insert: move entries up one slot, from the top down to tgt+1.
            // Reads arrive in the cycle after issue and are written at pidx+1.
            if (ptr_ff > tgt_ff + CW'(1)) begin
               rd_idx = IW'(ptr_ff - CW'(1)); pend_in = 1'b1;
               pidx_in = ptr_ff - CW'(1); ptr_in = ptr_ff - CW'(1);
            end
            if (pend_ff) begin
               wr_en = 1'b1; wr_idx = IW'(pidx_ff + CW'(1));
               wr_size = rd_size; wr_owner = rd_owner; wr_used = rd_used;
            end
            if (!(ptr_ff > tgt_ff + CW'(1)) && !pend_ff) state_in = ST_PLACE;
         end
         ST_PLACE: begin
            // Split: owner at tgt, remainder at tgt+1.
            if (!pend_ff) begin
               wr_en = 1'b1; wr_idx = tgt_ff[IW-1:0]; wr_size = reqf_ff;
               wr_owner = owner_ff; wr_used = 1'b1; pend_in = 1'b1;
            end else begin
               wr_en = 1'b1; wr_idx = IW'(tgt_ff + CW'(1));
               wr_size = bsize_ff - reqf_ff;
               count_in = count_ff + CW'(1); free_in = free_ff - reqf_ff;
               state_in = ST_DONE;
            end
         end
         ST_COMPACT: begin
            if (ptr_ff < count_ff) begin
               pend_in = 1'b1; pidx_in = ptr_ff; ptr_in = ptr_ff + CW'(1);
            end
            if (rd_ok) begin
               if (!rd_used) hole_in = 1'b1;
               else begin
                  if (hole_ff) moved_in = moved_ff + rd_size;
                  wr_en = 1'b1; wr_idx = wptr_ff[IW-1:0]; wr_size = rd_size;
                  wr_owner = rd_owner; wr_used = 1'b1; wptr_in = wptr_ff + CW'(1);
                  addr_in = (pidx_ff == '0) ? rd_size : addr_ff + rd_size;
               end
            end
            if (ptr_ff >= count_ff && !pend_ff) state_in = ST_TAIL;
         end
         ST_TAIL: begin
            // Start of tail = sum of used sizes = memory minus free.
            st_in = StatCompacted; rmoved_in = moved_ff;
            start_in = StartWidth'(mem_frames_ff - free_ff);
            tgt_in = wptr_ff; bsize_in = free_ff;
            if (free_ff == reqf_ff) begin
               wr_en = 1'b1; wr_idx = wptr_ff[IW-1:0]; wr_size = reqf_ff;
               wr_owner = owner_ff; wr_used = 1'b1;
               count_in = wptr_ff + CW'(1); free_in = '0; state_in = ST_DONE;
            end else begin
               count_in = wptr_ff + CW'(1); pend_in = 1'b0; state_in = ST_PLACE;
            end
         end
         ST_MERGE: begin
            // Write merged entry, then shift the rest down by rem slots.
            if (!pend_ff && ptr_ff == count_ff) begin
               // first cycle marker unused
            end
            if (rem_ff == 2'd0 && !pend_ff) begin
               wr_en = 1'b1; wr_idx = tgt_ff[IW-1:0]; wr_size = bsize_ff;
               wr_used = 1'b0; state_in = ST_DONE;
            end else if (!merge_l_ff && !merge_r_ff) begin
               state_in = ST_DONE;
            end else begin
               wr_en = !shift_up_ff; wr_idx = tgt_ff[IW-1:0]; wr_used = 1'b0;
               wr_size = bsize_ff + (merge_l_ff ? prevsz_ff : '0)
                         + (merge_r_ff ? nextsz_ff : '0);
               if (!shift_up_ff) begin
                  shift_up_in = 1'b1;
                  ptr_in = tgt_ff + CW'(1) + CW'(rem_ff);
               end else begin
                  wr_en = 1'b0;
                  if (ptr_ff < count_ff) begin
                     pend_in = 1'b1; pidx_in = ptr_ff; ptr_in = ptr_ff + CW'(1);
                  end
                  if (pend_ff) begin
                     wr_en = 1'b1; wr_idx = IW'(pidx_ff - CW'(rem_ff));
                     wr_size = rd_size; wr_owner = rd_owner; wr_used = rd_used;
                  end
                  if (ptr_ff >= count_ff && !pend_ff) begin
                     count_in = count_ff - CW'(rem_ff); state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1; state_in = ST_IDLE; shift_up_in = 1'b0;
         end
         default: state_in = ST_IDLE;
      endcase

      // A memory size write restarts the clearing pass, also from its last cycle.
      if (csr.valid && csr.ready) begin
         if (csr.index == CsrFitPolicy) fit_in = csr.data[0];
         else begin
            mem_frames_in = csr_clamp;
            state_in = ST_INIT; ptr_in = '0;
         end
      end

      // Merge state entry resets the shift flag.
      if (state_ff == ST_DECIDE && func_ff == FuncRelease) shift_up_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT; fit_ff <= 1'b0; mem_frames_ff <= FW'(256);
         count_ff <= CW'(1); free_ff <= FW'(256); rsp_valid_ff <= 1'b0;
         ptr_ff <= '0; pend_ff <= 1'b0; shift_up_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fit_ff <= fit_in; mem_frames_ff <= mem_frames_in;
         count_ff <= count_in; free_ff <= free_in; rsp_valid_ff <= rsp_valid_in;
         ptr_ff <= ptr_in; pend_ff <= pend_in; shift_up_ff <= shift_up_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in; owner_ff <= owner_in; reqf_ff <= reqf_in;
      pidx_ff <= pidx_in; addr_ff <= addr_in; have_ff <= have_in;
      best_ff <= best_in; bdiff_ff <= bdiff_in; bstart_ff <= bstart_in;
      bsize_ff <= bsize_in; used_n_ff <= used_n_in; hole_ff <= hole_in;
      moved_ff <= moved_in; wptr_ff <= wptr_in; prevsz_ff <= prevsz_in;
      prevfree_ff <= prevfree_in; merge_l_ff <= merge_l_in; merge_r_ff <= merge_r_in;
      nextsz_ff <= nextsz_in; rem_ff <= rem_in; tgt_ff <= tgt_in;
      st_ff <= st_in; start_ff <= start_in; rmoved_ff <= rmoved_in;
   end

   // A result holds while it waits to be taken, and no item enters meanwhile.
   `CSA_ASSERT_IMP(a_no_accept_busy, clock, reset, rsp_valid_ff, !req.ready)
   // When idle, free space never exceeds the managed memory size.
   `CSA_ASSERT_IMP(a_free_bound, clock, reset, state_ff == ST_IDLE, free_ff <= mem_frames_ff)
   // The table always holds at least one segment when idle.
   `CSA_ASSERT_IMP(a_count_min, clock, reset, state_ff == ST_IDLE, count_ff != '0)
   // An accepted item leads to work, never straight back to idle.
   `CSA_ASSERT_NEXT(a_accept_busy, clock, reset, req.valid && req.ready, state_ff != ST_IDLE)
endmodule

### hdl/csa_table.sv
// Segment table register file: one registered indexed read and one indexed write per cycle.
module csa_table #(
   parameter int MAX_SEGMENTS = csa_pkg::MaxSegments,
   parameter int FW           = csa_pkg::FrameWidth
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_SEGMENTS)-1:0] wr_idx,
   input  logic [FW-1:0]                   wr_size,
   input  logic [csa_pkg::OwnerWidth-1:0]  wr_owner,
   input  logic                            wr_used,
   input  logic [$clog2(MAX_SEGMENTS)-1:0] rd_idx,
   output logic [FW-1:0]                   rd_size,
   output logic [csa_pkg::OwnerWidth-1:0]  rd_owner,
   output logic                            rd_used
);
   import csa_pkg::*;
   logic [FW-1:0]         size_mem [MAX_SEGMENTS];
   logic [OwnerWidth-1:0] owner_mem[MAX_SEGMENTS];
   logic                  used_mem [MAX_SEGMENTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         size_mem[wr_idx]  <= wr_size;
         owner_mem[wr_idx] <= wr_owner;
         used_mem[wr_idx]  <= wr_used;
      end
      rd_size  <= size_mem[rd_idx];
      rd_owner <= owner_mem[rd_idx];
      rd_used  <= used_mem[rd_idx];
   end
endmodule
